// ----- rtl/core/srwd_pkg.sv -----
// ----------------------------------------------------------------------------
// Strip readout word decoder package
// Widths, codes and record type shared by the decoder and its interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package srwd_pkg;

  localparam int unsigned STRIPS_PER_SIDE_DEF = 768;
  localparam int unsigned MAX_LINK_DEF        = 95;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned ROB_W   = 24;
  localparam int unsigned LINK_W  = 7;
  localparam int unsigned ID_W    = 31;
  localparam int unsigned STRIP_W = 10;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CHIP_W  = 3;
  localparam int unsigned TAG_W   = 8;

  localparam logic [CHIP_W-1:0]  CHIP_MAX  = 3'd5;
  localparam logic [STRIP_W-1:0] STRIP_TOP = 10'h3FF;
  localparam logic [TAG_W-1:0]   TAG_LAST  = '1;
  localparam logic [TAG_W-1:0]   TAG_FIRST = TAG_W'(1);

  typedef enum logic [1:0] {
    CLS_ERROR   = 2'd0,
    CLS_HEADER  = 2'd1,
    CLS_TRAILER = 2'd2,
    CLS_RAW     = 2'd3
  } word_cls_e;

  typedef struct packed {
    logic [ID_W-1:0]    online_id;
    logic [STRIP_W-1:0] first_strip;
    logic [CNT_W-1:0]   strip_count;
    logic               last_of_run;
  } rec_t;

endpackage

`default_nettype wire

// ----- rtl/core/srwd_intf.sv -----
// ----------------------------------------------------------------------------
// Strip readout word decoder channels
// Valid/ready channels for readout words, hit records and the id register.
// ----------------------------------------------------------------------------
`default_nettype none

interface srwd_in_if import srwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic              fragment_end;

  modport source (output valid, output data_word, output fragment_end, input ready);
  modport sink (input valid, input data_word, input fragment_end, output ready);
endinterface

interface srwd_out_if import srwd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    online_id;
  logic [STRIP_W-1:0] first_strip;
  logic [CNT_W-1:0]   strip_count;
  logic               last_of_run;

  modport source (output valid, output online_id, output first_strip,
                  output strip_count, output last_of_run, input ready);
  modport sink (input valid, input online_id, input first_strip,
                input strip_count, input last_of_run, output ready);
endinterface

interface srwd_cfg_if import srwd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROB_W-1:0] rob_id_low;

  modport source (output valid, output rob_id_low, input ready);
  modport sink (input valid, input rob_id_low, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/srwd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module srwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 768,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/strip_readout_word_decoder_top.sv -----
// ----------------------------------------------------------------------------
// Strip readout word decoder
// Turns 16-bit readout words into hit records with link id, first strip and
// strip count, for condensed and expanded readout modes.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         per beat
//  word_i   in   data_word, fragment_end                         one word
//  rec_o    out  online_id, first_strip, strip_count, last_of_run one record
//  cfg_i    in   rob_id_low                                      register write
//
// A word is registered, decoded once the result register has room and its
// records land in a two-entry result register, so one word per cycle is taken
// while records drain at one per cycle; an expanded pair holds the input until
// a record of the pair has drained. After reset, and at every 255th header or
// fragment end, the saved-strip map RAM is swept clear over all STRIPS_PER_SIDE
// entries with word_i.ready low. The configuration channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module strip_readout_word_decoder_top
  import srwd_pkg::*;
#(
  parameter int unsigned STRIPS_PER_SIDE = STRIPS_PER_SIDE_DEF,
  parameter int unsigned MAX_LINK        = MAX_LINK_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  srwd_in_if.sink     word_i,
  srwd_out_if.source  rec_o,
  srwd_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = $clog2(STRIPS_PER_SIDE);
  localparam logic [STRIP_W:0]  SIDE_LIM  = (STRIP_W+1)'(STRIPS_PER_SIDE);
  localparam logic [AW-1:0]     CLR_LAST  = AW'(STRIPS_PER_SIDE - 1);
  localparam logic [LINK_W-1:0] LINK_LIM  = LINK_W'(MAX_LINK);

  function automatic logic in_side(input logic [STRIP_W-1:0] s);
    return {1'b0, s} < SIDE_LIM;
  endfunction

  function automatic logic [STRIP_W-1:0] strip_inc(input logic [STRIP_W-1:0] s);
    return (s == STRIP_TOP) ? s : s + STRIP_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] cnt_add(input logic [CNT_W-1:0] c,
                                               input logic two);
    logic [CNT_W:0] sum;
    sum = {1'b0, c} + (two ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  // Input register.
  logic              a_valid_q, a_valid_d;
  logic [WORD_W-1:0] a_word_q;
  logic              a_fe_q;

  // Result register.
  logic [1:0] cnt_q, cnt_d;
  rec_t       buf_q [2];

  // Decoder state.
  logic [ROB_W-1:0]   rob_q;
  logic [LINK_W-1:0]  link_q, link_d;
  logic               cond_q, cond_d;
  logic [CHIP_W-1:0]  chip_q, chip_d;
  logic [STRIP_W-1:0] cur_q, cur_d;
  logic [STRIP_W-1:0] start_q, start_d;
  logic               open_q, open_d;
  logic [CNT_W-1:0]   pend_q, pend_d;
  logic [ID_W-1:0]    hid_q, hid_d;
  logic               skip_q, skip_d;

  // Saved-strip map bookkeeping.
  logic [TAG_W-1:0] epoch_q, epoch_d;
  logic             clr_q, clr_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             bypass_q, bypass_d;
  logic [TAG_W-1:0] rd_tag;
  logic [AW-1:0]    rd_addr;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [TAG_W-1:0] ram_wdata;

  logic               advance, b_free, pop, saved, map_clr;
  logic               mark_en;
  logic [STRIP_W-1:0] mark_strip;
  logic [AW-1:0]      mark_addr;
  rec_t               ra, rb;
  logic               ea_v, eb_v;
  logic [1:0]         n_rec;

  logic [CHIP_W-1:0]  hit_chip;
  logic [STRIP_W-1:0] hit_strip, s1, s2, st;
  logic [CNT_W-1:0]   pc;
  logic [LINK_W-1:0]  hdr_link;
  word_cls_e          cls;

  assign pop     = rec_o.valid && rec_o.ready;
  assign b_free  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && rec_o.ready);
  assign advance = a_valid_q && b_free && !clr_q;

  assign word_i.ready = !clr_q && (!a_valid_q || advance);
  assign cfg_i.ready  = 1'b1;

  assign saved = !in_side(cur_q) || bypass_q || (rd_tag == epoch_q);

  assign hit_chip  = a_word_q[13:11];
  assign hit_strip = {a_word_q[13:11], a_word_q[10:4]};
  assign s1        = strip_inc(cur_q);
  assign s2        = strip_inc(s1);
  assign hdr_link  = LINK_W'({a_word_q[6:4], 3'b000}) + LINK_W'({a_word_q[6:4], 2'b00})
                   + LINK_W'(a_word_q[3:0]);
  assign cls       = word_cls_e'(a_word_q[14:13]);

  always_comb begin
    link_d  = link_q;
    cond_d  = cond_q;
    chip_d  = chip_q;
    cur_d   = cur_q;
    start_d = start_q;
    open_d  = open_q;
    pend_d  = pend_q;
    hid_d   = hid_q;
    skip_d  = skip_q;
    ea_v    = 1'b0;
    eb_v    = 1'b0;
    ra      = '{online_id: hid_q, first_strip: cur_q, strip_count: pend_q,
                last_of_run: 1'b0};
    rb      = '{online_id: hid_q, first_strip: s2, strip_count: CNT_W'(1),
                last_of_run: 1'b1};
    mark_en    = 1'b0;
    mark_strip = start_q;
    map_clr    = 1'b0;
    pc         = pend_q;
    st         = start_q;
    if (advance) begin
      priority if (a_fe_q) begin
        ea_v    = open_q && !saved && (pend_q != '0);
        link_d  = '0;
        cond_d  = 1'b1;
        chip_d  = '0;
        cur_d   = '0;
        start_d = '0;
        open_d  = 1'b0;
        pend_d  = '0;
        hid_d   = '0;
        skip_d  = 1'b0;
        map_clr = 1'b1;
      end else if (a_word_q[15]) begin
        if (!skip_q) begin
          if (cond_q || !a_word_q[3]) begin
            chip_d = hit_chip;
            cur_d  = hit_strip;
            if (hit_chip <= CHIP_MAX) begin
              link_d = {link_q[LINK_W-1:1], a_word_q[14]};
              hid_d  = {link_d, rob_q};
              if (cond_q) begin
                if (pc == '0) begin
                  st     = hit_strip;
                  open_d = 1'b1;
                end
                if (hit_strip != st) begin
                  ea_v       = in_side(st) && (pc != '0);
                  ra         = '{online_id: hid_d, first_strip: st, strip_count: pc,
                                 last_of_run: 1'b0};
                  mark_en    = in_side(st);
                  mark_strip = st;
                  st         = hit_strip;
                  open_d     = 1'b1;
                  pc         = '0;
                end
                start_d = st;
                pend_d  = cnt_add(pc, a_word_q[0]);
              end else begin
                ea_v   = in_side(hit_strip);
                ra     = '{online_id: hid_d, first_strip: hit_strip,
                           strip_count: CNT_W'(1), last_of_run: 1'b0};
                pend_d = '0;
              end
            end
          end else if (chip_q <= CHIP_MAX) begin
            ea_v   = in_side(s1);
            ra     = '{online_id: hid_q, first_strip: s1, strip_count: CNT_W'(1),
                       last_of_run: 1'b0};
            eb_v   = a_word_q[7] && in_side(s2);
            cur_d  = a_word_q[7] ? s2 : s1;
            pend_d = '0;
          end
        end
      end else begin
        unique case (cls)
          CLS_HEADER: begin
            ea_v    = open_q && !saved && (pend_q != '0);
            cur_d   = '0;
            start_d = '0;
            open_d  = 1'b0;
            pend_d  = '0;
            map_clr = 1'b1;
            link_d  = hdr_link;
            if (hdr_link > LINK_LIM) begin
              skip_d = 1'b1;
            end else begin
              skip_d = 1'b0;
              cond_d = a_word_q[8];
            end
          end
          CLS_ERROR: begin
            chip_d = a_word_q[5:3];
          end
          CLS_TRAILER, CLS_RAW: begin
          end
          default: begin
          end
        endcase
      end
    end
    ra.last_of_run = !eb_v;
  end

  assign n_rec = {1'b0, ea_v} + {1'b0, eb_v};

  always_comb begin
    if (advance) begin
      cnt_d = n_rec;
    end else begin
      cnt_d = cnt_q - {1'b0, pop};
    end
    a_valid_d = (word_i.valid && word_i.ready) ? 1'b1 : (advance ? 1'b0 : a_valid_q);
  end

  // Map epochs: an entry counts as saved while its tag equals the epoch.
  assign mark_addr = mark_strip[AW-1:0];
  assign rd_addr   = in_side(cur_d) ? cur_d[AW-1:0] : '0;
  assign bypass_d  = mark_en && (mark_addr == rd_addr);
  assign ram_we    = clr_q || mark_en;
  assign ram_waddr = clr_q ? clr_addr_q : mark_addr;
  assign ram_wdata = clr_q ? '0 : epoch_q;

  always_comb begin
    epoch_d    = epoch_q;
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == CLR_LAST) begin
        clr_d = 1'b0;
      end
    end else if (map_clr) begin
      if (epoch_q == TAG_LAST) begin
        clr_d      = 1'b1;
        clr_addr_d = '0;
        epoch_d    = TAG_FIRST;
      end else begin
        epoch_d = epoch_q + TAG_W'(1);
      end
    end
  end

  srwd_ram #(
    .WIDTH (TAG_W),
    .DEPTH (STRIPS_PER_SIDE)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      cnt_q      <= '0;
      rob_q      <= '0;
      link_q     <= '0;
      cond_q     <= 1'b1;
      chip_q     <= '0;
      cur_q      <= '0;
      start_q    <= '0;
      open_q     <= 1'b0;
      pend_q     <= '0;
      hid_q      <= '0;
      skip_q     <= 1'b0;
      epoch_q    <= TAG_FIRST;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      bypass_q   <= 1'b0;
    end else begin
      a_valid_q  <= a_valid_d;
      cnt_q      <= cnt_d;
      if (cfg_i.valid && cfg_i.ready) begin
        rob_q <= cfg_i.rob_id_low;
      end
      link_q     <= link_d;
      cond_q     <= cond_d;
      chip_q     <= chip_d;
      cur_q      <= cur_d;
      start_q    <= start_d;
      open_q     <= open_d;
      pend_q     <= pend_d;
      hid_q      <= hid_d;
      skip_q     <= skip_d;
      epoch_q    <= epoch_d;
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      bypass_q   <= bypass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_i.valid && word_i.ready) begin
      a_word_q <= word_i.data_word;
      a_fe_q   <= word_i.fragment_end;
    end
    if (advance && (n_rec != 2'd0)) begin
      buf_q[0] <= ea_v ? ra : rb;
      buf_q[1] <= rb;
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
    end
  end

  assign rec_o.valid       = (cnt_q != 2'd0);
  assign rec_o.online_id   = buf_q[0].online_id;
  assign rec_o.first_strip = buf_q[0].first_strip;
  assign rec_o.strip_count = buf_q[0].strip_count;
  assign rec_o.last_of_run = buf_q[0].last_of_run;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("Result register holds more than two records.");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!buf_q[0].last_of_run && buf_q[1].last_of_run))
    else $error("Record pair does not end with the last record of the beat.");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (!word_i.ready && !advance && !mark_en))
    else $error("Decoder active during the map clearing sweep.");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_q |-> (epoch_q != '0))
    else $error("Map epoch matches the cleared tag.");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_q && (clr_addr_q == CLR_LAST)) |=> (!clr_q && (epoch_q == TAG_FIRST)))
    else $error("Map clearing sweep did not end cleanly.");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Strip readout word decoder testbench
// Drives readout words and fragment ends through the valid/ready word channel,
// predicts every hit record in a scoreboard that tracks link, mode, cluster
// and saved-strip state, and checks each record beat in order. Directed words
// cover the corner cases, then random packets, noise, bad links and long runs
// are sent under three stall profiles and several id register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import srwd_pkg::*;

  localparam int LINKS_PER_GROUP = 12;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int SEGMENTS        = 6;
  localparam int SEGMENT_WORDS   = 80;

  class hit_record_scoreboard;
    logic [ROB_W-1:0]   rob_id;
    logic [LINK_W-1:0]  link;
    logic               cond_mode;
    logic [CHIP_W-1:0]  chip;
    logic [STRIP_W-1:0] cur_strip;
    logic [STRIP_W-1:0] start_strip;
    logic               cluster_open;
    logic [CNT_W-1:0]   hit_count;
    logic [ID_W-1:0]    held_id;
    bit                 saved_map [1024];
    logic               skip_hits;
    rec_t               step_records [$];
    rec_t               expected_records [$];
    int                 errors;
    int                 records_checked;

    function new();
      rob_id = '0;
      errors = 0;
      records_checked = 0;
      clear_state();
    endfunction

    function void clear_state();
      link = '0;
      cond_mode = 1'b1;
      chip = '0;
      cur_strip = '0;
      start_strip = '0;
      cluster_open = 1'b0;
      hit_count = '0;
      held_id = '0;
      foreach (saved_map[k]) saved_map[k] = 1'b0;
      skip_hits = 1'b0;
    endfunction

    function void set_rob(logic [ROB_W-1:0] value);
      rob_id = value;
    endfunction

    function bit in_side(logic [STRIP_W-1:0] s);
      return s < STRIPS_PER_SIDE_DEF;
    endfunction

    function void mark(logic [STRIP_W-1:0] s);
      if (in_side(s)) saved_map[s] = 1'b1;
    endfunction

    function void emit(logic [STRIP_W-1:0] s, logic [CNT_W-1:0] cnt);
      rec_t r;
      if (!in_side(s) || cnt == 0 || step_records.size() >= 2) return;
      r.online_id = held_id;
      r.first_strip = s;
      r.strip_count = cnt;
      r.last_of_run = 1'b0;
      step_records.push_back(r);
    endfunction

    function void flush();
      if (cluster_open && in_side(cur_strip) && !saved_map[cur_strip]) begin
        emit(cur_strip, hit_count);
        mark(cur_strip);
      end
    endfunction

    function void set_side(logic side);
      if (side && !link[0]) link = link + 1'b1;
      if (!side && link[0]) link = link - 1'b1;
      held_id = {link, rob_id};
    endfunction

    function void count_up();
      if (hit_count != '1) hit_count = hit_count + 1'b1;
    endfunction

    function void next_strip();
      if (cur_strip != STRIP_TOP) cur_strip = cur_strip + 1'b1;
    endfunction

    function void decode_hit(logic [WORD_W-1:0] w);
      if (cond_mode || !w[3]) begin
        chip = w[13:11];
        cur_strip = {chip, w[10:4]};
        if (chip > CHIP_MAX) return;
        set_side(w[14]);
        if (cond_mode) begin
          if (hit_count == 0) begin
            start_strip = cur_strip;
            cluster_open = 1'b1;
          end
          if (cur_strip != start_strip) begin
            emit(start_strip, hit_count);
            mark(start_strip);
            start_strip = cur_strip;
            cluster_open = 1'b1;
            hit_count = '0;
          end
          count_up();
          if (w[0]) count_up();
        end else begin
          emit(cur_strip, CNT_W'(1));
          mark(cur_strip);
          hit_count = '0;
        end
        return;
      end
      if (chip > CHIP_MAX) return;
      next_strip();
      emit(cur_strip, CNT_W'(1));
      mark(cur_strip);
      if (w[7]) begin
        next_strip();
        emit(cur_strip, CNT_W'(1));
        mark(cur_strip);
      end
      hit_count = '0;
    endfunction

    function void decode_header(logic [WORD_W-1:0] w);
      int lnk;
      flush();
      cur_strip = '0;
      start_strip = '0;
      cluster_open = 1'b0;
      hit_count = '0;
      foreach (saved_map[k]) saved_map[k] = 1'b0;
      lnk = int'(w[6:4]) * LINKS_PER_GROUP + int'(w[3:0]);
      link = LINK_W'(lnk);
      if (lnk > MAX_LINK_DEF) begin
        skip_hits = 1'b1;
        return;
      end
      skip_hits = 1'b0;
      cond_mode = w[8];
    endfunction

    function void note_word(logic frag, logic [WORD_W-1:0] w);
      logic [ROB_W-1:0] keep;
      step_records.delete();
      if (frag) begin
        flush();
        keep = rob_id;
        clear_state();
        rob_id = keep;
      end else if (w[15]) begin
        if (!skip_hits) decode_hit(w);
      end else if (word_cls_e'(w[14:13]) == CLS_HEADER) begin
        decode_header(w);
      end else if (word_cls_e'(w[14:13]) == CLS_ERROR) begin
        chip = w[5:3];
      end
      if (step_records.size() > 0)
        step_records[step_records.size() - 1].last_of_run = 1'b1;
      foreach (step_records[k]) expected_records.push_back(step_records[k]);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_record(rec_t got);
      rec_t want;
      records_checked++;
      if (expected_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record id %h strip %0d count %0d",
                                  got.online_id, got.first_strip, got.strip_count));
        return;
      end
      want = expected_records.pop_front();
      if (got.online_id !== want.online_id)
        report_mismatch($sformatf("online_id %h, expected %h",
                                  got.online_id, want.online_id));
      if (got.first_strip !== want.first_strip)
        report_mismatch($sformatf("first_strip %0d, expected %0d",
                                  got.first_strip, want.first_strip));
      if (got.strip_count !== want.strip_count)
        report_mismatch($sformatf("strip_count %0d, expected %0d",
                                  got.strip_count, want.strip_count));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b, expected %b",
                                  got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   words_sent;
  int   settings_used;
  int   cycle_count;

  hit_record_scoreboard board;

  srwd_in_if  word_if ();
  srwd_out_if rec_if ();
  srwd_cfg_if cfg_if ();

  strip_readout_word_decoder_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .word_i (word_if),
    .rec_o  (rec_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    rec_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    rec_t got;
    if (rst_n && rec_if.valid && rec_if.ready) begin
      got.online_id = rec_if.online_id;
      got.first_strip = rec_if.first_strip;
      got.strip_count = rec_if.strip_count;
      got.last_of_run = rec_if.last_of_run;
      board.check_record(got);
    end
  end

  task automatic send_beat(logic frag, logic [WORD_W-1:0] w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      word_if.valid <= 1'b0;
      @(negedge clk);
    end
    word_if.valid <= 1'b1;
    word_if.data_word <= w;
    word_if.fragment_end <= frag;
    do @(posedge clk); while (!word_if.ready);
    board.note_word(frag, w);
    if (frag || w[15] || !w[14]) words_sent++;
  endtask

  task automatic send_word(logic [WORD_W-1:0] w);
    send_beat(1'b0, w);
  endtask

  task automatic send_end();
    send_beat(1'b1, WORD_W'($urandom));
  endtask

  task automatic write_rob_id(logic [ROB_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.rob_id_low <= value;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_rob(value);
    settings_used++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // A word can sit in the input register with no record still owed, so the
  // decoder is idle only once the records are in and the input side is open.
  task automatic drain();
    @(negedge clk);
    word_if.valid <= 1'b0;
    while (board.expected_records.size() != 0 || !word_if.ready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] header_word(logic cond, logic [6:0] raw);
    return {3'b001, 4'($urandom_range(15)), cond, 1'($urandom_range(1)), raw};
  endfunction

  function automatic logic [6:0] valid_link_raw();
    logic [2:0] group;
    logic [3:0] index;
    group = 3'($urandom_range(7));
    index = 4'($urandom_range(group == 3'd7 ? 11 : 15));
    return {group, index};
  endfunction

  function automatic logic [CHIP_W-1:0] pick_chip();
    if ($urandom_range(9) == 0) return CHIP_W'(6 + $urandom_range(1));
    return CHIP_W'($urandom_range(5));
  endfunction

  function automatic logic [WORD_W-1:0] cond_hit(logic [CHIP_W-1:0] c, logic [6:0] s,
                                                 logic dbl);
    return {1'b1, 1'($urandom_range(1)), c, s, 3'($urandom_range(7)), dbl};
  endfunction

  function automatic logic [WORD_W-1:0] exp_first(logic [CHIP_W-1:0] c, logic [6:0] s);
    return {1'b1, 1'($urandom_range(1)), c, s, 1'b0, 3'($urandom_range(7))};
  endfunction

  function automatic logic [WORD_W-1:0] exp_next(logic pair);
    logic [WORD_W-1:0] w;
    w = WORD_W'($urandom);
    w[15] = 1'b1;
    w[3] = 1'b1;
    w[7] = pair;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] class_word(word_cls_e cls);
    return {1'b0, 2'(cls), 13'($urandom)};
  endfunction

  task automatic send_packet();
    logic             cond;
    int               hits;
    logic [CHIP_W-1:0] c;
    logic [6:0]       base;
    cond = 1'($urandom_range(1));
    send_word(header_word(cond, valid_link_raw()));
    hits = $urandom_range(1, 12);
    c = pick_chip();
    base = 7'($urandom_range(127));
    for (int k = 0; k < hits; k++) begin
      if ($urandom_range(9) == 0) send_word(class_word(CLS_ERROR));
      if (cond) begin
        if ($urandom_range(4) == 0) begin
          c = pick_chip();
          base = 7'($urandom_range(127));
        end
        send_word(cond_hit(c, base + 7'($urandom_range(3)), 1'($urandom_range(1))));
      end else if (k == 0 || $urandom_range(3) == 0) begin
        c = pick_chip();
        base = 7'($urandom_range(127));
        if ($urandom_range(9) == 0) begin
          c = CHIP_MAX;
          base = 7'($urandom_range(120, 127));
        end
        send_word(exp_first(c, base));
      end else begin
        send_word(exp_next(1'($urandom_range(1))));
      end
    end
    if ($urandom_range(4) == 0) send_end();
  endtask

  task automatic send_bad_link();
    send_word(header_word(1'($urandom_range(1)), {3'd7, 4'($urandom_range(12, 15))}));
    repeat ($urandom_range(1, 4)) send_word(WORD_W'($urandom) | 16'h8000);
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_word(WORD_W'($urandom));
      1: send_word(class_word(CLS_ERROR));
      2: send_word(class_word(CLS_TRAILER));
      default: send_word(class_word(CLS_RAW));
    endcase
  endtask

  task automatic send_count_run();
    logic [CHIP_W-1:0] c;
    logic [6:0]        s;
    c = CHIP_W'($urandom_range(5));
    s = 7'($urandom_range(126));
    send_word(header_word(1'b1, valid_link_raw()));
    repeat (130) send_word(cond_hit(c, s, 1'b1));
    send_word(cond_hit(c, s + 1'b1, 1'b0));
    send_end();
  endtask

  task automatic send_strip_run();
    send_word(header_word(1'b0, valid_link_raw()));
    send_word(exp_first(CHIP_MAX, 7'h7F));
    repeat (130) send_word(exp_next(1'b1));
    send_end();
  endtask

  task automatic send_directed();
    send_word(16'h2100);
    send_word(16'h8001);
    send_word(16'h8000);
    send_word(16'hEFF0);
    send_word(16'hB050);
    send_word(16'h207B);
    send_word(16'hAFE0);
    send_word(16'h8088);
    send_word(16'h8008);
    send_word(16'h0038);
    send_word(16'h8088);
    send_word(16'h4000);
    send_word(16'h6000);
    send_word(16'h87F0);
    send_word(16'h217C);
    send_word(16'hFFFF);
    send_end();
    send_word(16'h3F3F);
    send_word(16'h90A1);
    send_word(16'h90B0);
    send_word(16'h90A0);
    send_word(16'h2100);
    send_word(16'h8010);
    send_end();
    send_end();
  endtask

  initial begin
    int               target;
    int               pick;
    logic [ROB_W-1:0] seg_rob [SEGMENTS];
    clk = 1'b0;
    rst_n = 1'b0;
    cycle_count = 0;
    words_sent = 0;
    settings_used = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    word_if.valid = 1'b0;
    word_if.data_word = '0;
    word_if.fragment_end = 1'b0;
    rec_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.rob_id_low = '0;
    board = new();
    seg_rob[0] = '0;
    seg_rob[1] = ROB_W'($urandom);
    seg_rob[2] = '1;
    seg_rob[3] = ROB_W'($urandom);
    seg_rob[4] = 24'h800001;
    seg_rob[5] = ROB_W'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_rob_id('1);
    send_directed();
    drain();

    target = words_sent;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_rob_id(seg_rob[seg]);
      if (seg == 1) send_count_run();
      if (seg == 4) send_strip_run();
      target += SEGMENT_WORDS;
      while (words_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 70) send_packet();
        else if (pick < 85) send_noise();
        else if (pick < 92) send_bad_link();
        else send_end();
      end
      drain();
    end

    if (board.expected_records.size() != 0)
      board.report_mismatch($sformatf("%0d records never arrived",
                                      board.expected_records.size()));
    $display("Sent %0d readout words and checked %0d hit records over %0d id settings,",
             words_sent, board.records_checked, settings_used);
    $display("with sender stalls, receiver stalls and free-running traffic in turn.");
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
